[rtl/assert_macros.svh]
// Assertion helpers for the acceptance table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/crxf_pkg.sv]
`default_nettype none
package crxf_pkg;
	localparam int TABLE_ENTRIES_DEF = 16;
	localparam logic [10:0] MUX_ID_RST = 11'h180;
	localparam logic [7:0] STALE_RST = 8'd20;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_FRAME = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;
	localparam logic [1:0] FUNC_READ = 2'd3;

	localparam logic CFG_MUX_ID = 1'b0;
	localparam logic CFG_STALE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	// Item travelling down the chain
	typedef struct packed {
		logic        vld;
		logic [1:0]  func;
		logic [10:0] std_id;
		logic [28:0] ext_id;
		logic        is_ext;
		logic [63:0] payload;
		logic [3:0]  index;
		logic [28:0] e_id;
		logic        e_ext;
		logic [7:0]  e_regid;
		logic        e_en;
		logic [10:0] mux_id;
		logic [7:0]  stale_lim;
		logic        taken;
		logic        matched;
		logic [3:0]  m_index;
		logic [63:0] s_payload;
		logic        fresh;
		logic [15:0] rcount;
		logic [15:0] stale_mask;
	} chain_t;
endpackage
`default_nettype wire

[rtl/can_rx_id_match_table_with_timeout.sv]
// Channel   | Handshake        | Payload
// command   | start / busy     | func, std_id, ext_id, is_extended, payload, entry_*
// result    | done strobe      | matched, match_index, stored_payload, fresh, ...
// config    | cfg_we           | cfg_index, cfg_data
// An item walks one cell per cycle, and done is high when it leaves the last cell.
// busy rises at acceptance and falls at the edge that ends the done cycle, so
// no new item is accepted until the previous one has produced its result.
// Reset clears all entries and restores register defaults.
// The result is shown for one cycle on done; the receiver cannot stall.
`default_nettype none
module can_rx_id_match_table_with_timeout #(
	parameter int unsigned TABLE_ENTRIES = crxf_pkg::TABLE_ENTRIES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  func,
	input  wire  [10:0] std_id,
	input  wire  [28:0] ext_id,
	input  wire         is_extended,
	input  wire  [63:0] payload,
	input  wire  [3:0]  entry_index,
	input  wire  [28:0] entry_id,
	input  wire         entry_is_extended,
	input  wire  [7:0]  entry_regid,
	input  wire         entry_enable,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [10:0] cfg_data,
	output logic        done,
	output logic        matched,
	output logic [3:0]  match_index,
	output logic [63:0] stored_payload,
	output logic        fresh,
	output logic [15:0] receive_count,
	output logic [15:0] stale_mask
);
	`include "assert_macros.svh"

	crxf_pkg::chain_t link [TABLE_ENTRIES+1];
	crxf_pkg::chain_t head;
	logic [10:0] mux_q;
	logic [7:0]  stale_q;
	logic        acc;

	assign acc = start && !busy;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mux_q <= crxf_pkg::MUX_ID_RST;
			stale_q <= crxf_pkg::STALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				crxf_pkg::CFG_MUX_ID: mux_q <= cfg_data;
				default: stale_q <= cfg_data[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy <= 1'b0;
		else if (acc) busy <= 1'b1;
		else if (link[TABLE_ENTRIES].vld) busy <= 1'b0;
	end

	// Head of chain
	always_comb begin
		head = '0;
		head.vld = acc;
		head.func = func;
		head.std_id = std_id;
		head.ext_id = ext_id;
		head.is_ext = is_extended;
		head.payload = payload;
		head.index = entry_index;
		head.e_id = entry_id;
		head.e_ext = entry_is_extended;
		head.e_regid = entry_regid;
		head.e_en = entry_enable;
		head.mux_id = mux_q;
		head.stale_lim = stale_q;
		if (func == crxf_pkg::FUNC_LOAD || func == crxf_pkg::FUNC_READ)
			head.m_index = entry_index;
	end
	assign link[0] = head;

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		crxf_cell #(.POS(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .prev(link[g]), .next(link[g+1])
		);
	end

	assign done = link[TABLE_ENTRIES].vld;
	assign matched = link[TABLE_ENTRIES].matched;
	assign match_index = link[TABLE_ENTRIES].m_index;
	assign stored_payload = link[TABLE_ENTRIES].s_payload;
	assign fresh = link[TABLE_ENTRIES].fresh;
	assign receive_count = link[TABLE_ENTRIES].rcount;
	assign stale_mask = link[TABLE_ENTRIES].stale_mask;

	`ASSERT_CLK(a_done_busy, clk, arst_n, !done || busy, "done without busy")
	`ASSERT_NEXT(a_acc_busy, clk, arst_n, acc, busy, "busy not set after start")
	`ASSERT_CLK(a_tick_clean, clk, arst_n,
		!(done && link[TABLE_ENTRIES].func == crxf_pkg::FUNC_TICK) || !matched,
		"tick result shows a match")
endmodule
`default_nettype wire

[rtl/crxf_cell.sv]
`default_nettype none
module crxf_cell #(
	parameter int unsigned POS = 0
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  crxf_pkg::chain_t       prev,
	output crxf_pkg::chain_t       next
);
	logic [28:0] id_q;
	logic        ext_q;
	logic [7:0]  regid_q;
	logic        en_q;
	logic [63:0] data_q;
	logic        fresh_q;
	logic [15:0] rcnt_q;
	logic [15:0] seen_q;
	logic [7:0]  miss_q;

	logic        addr_hit;
	logic        hit;
	logic [7:0]  miss_nx;
	logic        is_stale;
	crxf_pkg::chain_t nx;

	assign addr_hit = ({26'd0, prev.index} == 30'(POS));

	// Matching rules, first enabled entry wins
	always_comb begin
		hit = en_q && !prev.taken && (
			({18'd0, prev.std_id} == id_q && prev.is_ext == ext_q &&
				prev.std_id != prev.mux_id) ||
			({18'd0, prev.std_id} == id_q && prev.payload[7:0] == regid_q) ||
			(prev.ext_id == id_q && prev.is_ext == ext_q));
		miss_nx = (rcnt_q == seen_q) ? ((miss_q == 8'hff) ? miss_q : miss_q + 8'd1) : 8'd0;
		is_stale = en_q && (miss_nx >= prev.stale_lim);
	end

	always_comb begin
		nx = prev;
		if (prev.vld) begin
			case (prev.func)
				crxf_pkg::FUNC_LOAD: begin
					if (addr_hit) begin
						nx.matched = prev.e_en;
						nx.s_payload = '0;
						nx.fresh = 1'b0;
						nx.rcount = '0;
					end
				end
				crxf_pkg::FUNC_READ: begin
					if (addr_hit) begin
						nx.matched = en_q;
						nx.s_payload = data_q;
						nx.fresh = fresh_q;
						nx.rcount = rcnt_q;
					end
				end
				crxf_pkg::FUNC_FRAME: begin
					if (hit) begin
						nx.taken = 1'b1;
						nx.matched = 1'b1;
						nx.m_index = 4'(POS);
						nx.s_payload = prev.payload;
						nx.fresh = 1'b1;
						nx.rcount = rcnt_q + 16'd1;
					end
				end
				default: begin
					if (POS < 16 && is_stale)
						nx.stale_mask[POS % 16] = 1'b1;
				end
			endcase
		end
	end

	// Entry state; loads, captures, clears fresh and ages as the item passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= '0; ext_q <= 1'b0; regid_q <= '0; en_q <= 1'b0;
			data_q <= '0; fresh_q <= 1'b0; rcnt_q <= '0; seen_q <= '0; miss_q <= '0;
		end else if (prev.vld) begin
			case (prev.func)
				crxf_pkg::FUNC_LOAD: begin
					if (addr_hit) begin
						id_q <= prev.e_id; ext_q <= prev.e_ext;
						regid_q <= prev.e_regid; en_q <= prev.e_en;
						data_q <= '0; fresh_q <= 1'b0; rcnt_q <= '0;
						seen_q <= '0; miss_q <= '0;
					end
				end
				crxf_pkg::FUNC_READ: begin
					if (addr_hit) fresh_q <= 1'b0;
				end
				crxf_pkg::FUNC_FRAME: begin
					if (hit) begin
						data_q <= prev.payload;
						fresh_q <= 1'b1;
						rcnt_q <= rcnt_q + 16'd1;
					end
				end
				default: begin
					miss_q <= miss_nx;
					if (rcnt_q != seen_q) seen_q <= rcnt_q;
				end
			endcase
		end
	end

	// Hand item to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) next <= '0;
		else next <= nx;
	end
endmodule
`default_nettype wire
